// ===== rtl/cth_pkg.sv =====
package cth_pkg;

    typedef enum logic [3:0] {
        PH_TYPE_LEAD   = 4'd0,
        PH_TYPE        = 4'd1,
        PH_NAME_LEAD   = 4'd2,
        PH_NAME        = 4'd3,
        PH_AFTER_NAME  = 4'd4,
        PH_VALUE_LEAD  = 4'd5,
        PH_TOKEN_VALUE = 4'd6,
        PH_QUOTED      = 4'd7,
        PH_QUOTED_ESC  = 4'd8,
        PH_AFTER_VALUE = 4'd9,
        PH_ERR         = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        V_NO_MATCH    = 3'd0,
        V_MATCH       = 3'd1,
        V_MALFORMED   = 3'd2,
        V_TOO_LARGE   = 3'd3,
        V_UNSUPPORTED = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_MALFORMED   = 2'd1,
        ERR_UNSUPPORTED = 2'd2
    } err_t;

    localparam logic CFG_JSON_MODE  = 1'b0;
    localparam logic CFG_BODY_LIMIT = 1'b1;

    localparam logic [5:0]  LEN_SAT    = 6'd34;
    localparam logic [3:0]  MISMATCH   = 4'd15;
    localparam logic [39:0] PLUS_JSON  = 40'h2B6A736F6E;
    localparam logic [31:0] LIMIT_INIT = 32'd102400;
    localparam int          QDEPTH     = 2;

    // Classified header, passed from the parser to the verdict stage.
    typedef struct packed {
        logic       type_ok;
        logic [1:0] err;
        logic       absent;
        logic [31:0] body_length;
    } job_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09);
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || ((c >= 8'h30) && (c <= 8'h39));
        unique case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
    endfunction

    function automatic logic is_ctl(input logic [7:0] c);
        return ((c < 8'd32) && (c != 8'h09)) || (c == 8'd127);
    endfunction

    function automatic logic [7:0] json_chr(input logic [5:0] i);
        logic [127:0] s;
        s = "application/json";
        return s[8'(127 - 8 * i) -: 8];
    endfunction

    function automatic logic [7:0] form_chr(input logic [5:0] i);
        logic [263:0] s;
        s = "application/x-www-form-urlencoded";
        return s[9'(263 - 8 * i) -: 8];
    endfunction

    function automatic logic [7:0] cs_chr(input logic [3:0] i);
        logic [55:0] s;
        s = "charset";
        return s[6'(55 - 8 * i) -: 8];
    endfunction

    function automatic logic [7:0] utf_chr(input logic [3:0] i);
        logic [39:0] s;
        s = "utf-8";
        return s[6'(39 - 8 * i) -: 8];
    endfunction

endpackage

// ===== rtl/cth_parser.sv =====
module cth_parser
    import cth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  header_byte,
    input  logic        header_absent,
    input  logic        last_byte,
    input  logic [31:0] body_length,
    input  logic        json_mode,
    output logic        job_valid,
    output job_t        job,
    input  logic        job_full
);

    phase_t      phase_reg, phase_next;
    logic [5:0]  len_reg, len_next;
    logic        sp_reg, sp_next;
    logic [2:0]  flags_reg, flags_next;
    logic [39:0] tail_reg, tail_next;
    logic [3:0]  nprog_reg, nprog_next;
    logic [3:0]  vprog_reg, vprog_next;
    logic        cs_seen_reg, cs_seen_next;
    logic [1:0]  err_reg, err_next;

    logic       take;
    logic [7:0] lc;
    logic [5:0] len_i;
    logic [1:0] err_f;
    logic       type_ok;

    assign in_ready = !job_full;
    assign take     = in_valid && in_ready;
    assign lc       = to_lower(header_byte);

    always_comb
    begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        sp_next      = sp_reg;
        flags_next   = flags_reg;
        tail_next    = tail_reg;
        nprog_next   = nprog_reg;
        vprog_next   = vprog_reg;
        cs_seen_next = cs_seen_reg;
        err_next     = err_reg;
        len_i        = len_reg;
        err_f        = err_reg;
        type_ok      = 1'b0;
        job          = '0;
        job_valid    = 1'b0;

        if (take && !header_absent)
        begin
            unique case (phase_reg)
                PH_TYPE_LEAD, PH_TYPE:
                begin
                    if (header_byte == 8'h3B)
                        phase_next = PH_NAME_LEAD;
                    else if (is_ws(header_byte))
                    begin
                        if (phase_reg == PH_TYPE)
                            sp_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                        if (sp_reg)
                            flags_next = '0;
                        if (!(len_i < 6'd16 && lc == json_chr(len_i)))
                            flags_next[0] = 1'b0;
                        if (len_i < 6'd12)
                        begin
                            if (lc != json_chr(len_i))
                                flags_next[1] = 1'b0;
                        end
                        else if (!is_token(lc))
                            flags_next[1] = 1'b0;
                        if (!(len_i < 6'd33 && lc == form_chr(len_i)))
                            flags_next[2] = 1'b0;
                        if (len_reg < LEN_SAT)
                            len_next = len_reg + 6'd1;
                        tail_next = {tail_reg[31:0], lc};
                    end
                end
                PH_NAME_LEAD, PH_NAME:
                begin
                    if (is_token(header_byte))
                    begin
                        phase_next = PH_NAME;
                        nprog_next = (nprog_reg < 4'd7 && lc == cs_chr(nprog_reg))
                                     ? nprog_reg + 4'd1 : MISMATCH;
                    end
                    else if (is_ws(header_byte))
                    begin
                        if (phase_reg == PH_NAME)
                            phase_next = PH_AFTER_NAME;
                    end
                    else if (phase_reg == PH_NAME && header_byte == 8'h3D)
                        phase_next = PH_VALUE_LEAD;
                    else
                        phase_next = PH_ERR;
                end
                PH_AFTER_NAME:
                begin
                    if (header_byte == 8'h3D)
                        phase_next = PH_VALUE_LEAD;
                    else if (!is_ws(header_byte))
                        phase_next = PH_ERR;
                end
                PH_VALUE_LEAD, PH_TOKEN_VALUE:
                begin
                    if (phase_reg == PH_VALUE_LEAD && header_byte == 8'h22)
                        phase_next = PH_QUOTED;
                    else if (is_token(header_byte))
                    begin
                        phase_next = PH_TOKEN_VALUE;
                        vprog_next = (vprog_reg < 4'd5 && lc == utf_chr(vprog_reg))
                                     ? vprog_reg + 4'd1 : MISMATCH;
                    end
                    else if (is_ws(header_byte))
                    begin
                        if (phase_reg == PH_TOKEN_VALUE)
                            phase_next = PH_AFTER_VALUE;
                    end
                    else if (phase_reg == PH_TOKEN_VALUE && header_byte == 8'h3B)
                        phase_next = PH_NAME_LEAD;
                    else
                        phase_next = PH_ERR;
                end
                PH_QUOTED, PH_QUOTED_ESC:
                begin
                    if (phase_reg == PH_QUOTED && header_byte == 8'h22)
                        phase_next = PH_AFTER_VALUE;
                    else if (phase_reg == PH_QUOTED && header_byte == 8'h5C)
                        phase_next = PH_QUOTED_ESC;
                    else if (is_ctl(header_byte))
                        phase_next = PH_ERR;
                    else
                    begin
                        phase_next = PH_QUOTED;
                        vprog_next = (vprog_reg < 4'd5 && lc == utf_chr(vprog_reg))
                                     ? vprog_reg + 4'd1 : MISMATCH;
                    end
                end
                PH_AFTER_VALUE:
                begin
                    if (header_byte == 8'h3B)
                        phase_next = PH_NAME_LEAD;
                    else if (!is_ws(header_byte))
                        phase_next = PH_ERR;
                end
                default: ;
            endcase

            // Syntax error raised by this byte.
            if (phase_next == PH_ERR && phase_reg != PH_ERR && err_next == ERR_NONE)
                err_next = ERR_MALFORMED;

            // A parameter closes on ';' or at the end of the header in a value phase.
            if ((phase_reg == PH_TOKEN_VALUE || phase_reg == PH_AFTER_VALUE)
                && phase_next == PH_NAME_LEAD
                || (last_byte && (phase_next == PH_TOKEN_VALUE
                                  || phase_next == PH_AFTER_VALUE)))
            begin
                if (nprog_next == 4'd7)
                begin
                    if (cs_seen_reg)
                    begin
                        if (err_next == ERR_NONE)
                            err_next = ERR_MALFORMED;
                        phase_next = PH_ERR;
                    end
                    else
                    begin
                        cs_seen_next = 1'b1;
                        if (vprog_next != 4'd5)
                        begin
                            if (err_next == ERR_NONE)
                                err_next = ERR_UNSUPPORTED;
                            phase_next = PH_ERR;
                        end
                    end
                end
                nprog_next = '0;
                vprog_next = '0;
            end

            // A header that ends inside a parameter, including after a
            // trailing ';', is malformed.
            if (last_byte && phase_next != PH_TYPE_LEAD && phase_next != PH_TYPE
                && phase_next != PH_TOKEN_VALUE && phase_next != PH_AFTER_VALUE
                && phase_next != PH_ERR && err_next == ERR_NONE)
                err_next = ERR_MALFORMED;
        end

        err_f = err_next;
        if (json_mode)
            type_ok = (flags_next[0] && len_next == 6'd16)
                   || (flags_next[1] && len_next > 6'd17 && tail_next == PLUS_JSON);
        else
            type_ok = flags_next[2] && len_next == 6'd33;

        if (take && last_byte)
        begin
            job_valid        = 1'b1;
            job.type_ok      = type_ok;
            job.err          = err_f;
            job.absent       = header_absent;
            job.body_length  = body_length;
            phase_next   = PH_TYPE_LEAD;
            len_next     = '0;
            sp_next      = 1'b0;
            flags_next   = '1;
            tail_next    = '0;
            nprog_next   = '0;
            vprog_next   = '0;
            cs_seen_next = 1'b0;
            err_next     = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TYPE_LEAD;
            len_reg     <= '0;
            sp_reg      <= 1'b0;
            flags_reg   <= '1;
            tail_reg    <= '0;
            nprog_reg   <= '0;
            vprog_reg   <= '0;
            cs_seen_reg <= 1'b0;
            err_reg     <= ERR_NONE;
        end
        else
        begin
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            sp_reg      <= sp_next;
            flags_reg   <= flags_next;
            tail_reg    <= tail_next;
            nprog_reg   <= nprog_next;
            vprog_reg   <= vprog_next;
            cs_seen_reg <= cs_seen_next;
            err_reg     <= err_next;
        end
    end

`ifndef SYNTHESIS
    a_len_sat: assert property (@(posedge clk) disable iff (!rst_n) len_reg <= LEN_SAT)
        else $error("type length beyond saturation");
    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        take && last_byte |=> phase_reg == PH_TYPE_LEAD && err_reg == ERR_NONE)
        else $error("header state not cleared after last byte");
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERR && !(take && last_byte) |=> phase_reg == PH_ERR)
        else $error("error phase left early");
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERR |-> err_reg != ERR_NONE)
        else $error("error phase without error code");
`endif

endmodule

// ===== rtl/cth_queue.sv =====
module cth_queue
    import cth_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    output logic empty,
    input  logic pop,
    output job_t pop_data
);

    localparam int AW = $clog2(QDEPTH);

    job_t          mem_reg [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign full     = (cnt_reg == (AW+1)'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + AW'(1);
            if (pop)
                rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("queue underflow");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(QDEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ===== rtl/cth_verdict.sv =====
module cth_verdict
    import cth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_ready,
    input  job_t        job,
    output logic        job_pop,
    input  logic [31:0] body_limit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  verdict
);

    logic     valid_reg;
    verdict_t verdict_reg, verdict_next;

    assign job_pop   = job_ready && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign verdict   = verdict_reg;

    always_comb
    begin
        priority if (job.absent || !job.type_ok)
            verdict_next = V_NO_MATCH;
        else if (job.body_length > body_limit)
            verdict_next = V_TOO_LARGE;
        else if (job.err == ERR_MALFORMED)
            verdict_next = V_MALFORMED;
        else if (job.err == ERR_UNSUPPORTED)
            verdict_next = V_UNSUPPORTED;
        else
            verdict_next = V_MATCH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (job_pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
            verdict_reg <= verdict_next;
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(verdict_reg))
        else $error("result dropped while stalled");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> verdict_reg <= V_UNSUPPORTED)
        else $error("verdict out of range");
    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !valid_reg || out_ready)
        else $error("pop without output room");
`endif

endmodule

// ===== rtl/content_type_header_checker.sv =====
// A verdict passes from the parser through the job queue into the verdict register; a stalled receiver holds it back.
// Throughput: one header byte per cycle while the job queue has room; the parser state is registered.
// A two-entry queue between the parser and the verdict register lets either side stall.
// Reset (rst_n low, asynchronous) clears the parser state, empties the queue and the
// output register, and sets json_mode to 0 and body_limit to 102400.
module content_type_header_checker
    import cth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  header_byte,
    input  logic        header_absent,
    input  logic        last_byte,
    input  logic [31:0] body_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  verdict,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration registers; the user must write them only while the checker is idle, the block does not enforce it.
    logic        json_mode_reg;
    logic [31:0] body_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            json_mode_reg  <= 1'b0;
            body_limit_reg <= LIMIT_INIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_JSON_MODE:  json_mode_reg  <= cfg_data[0];
                CFG_BODY_LIMIT: body_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front: byte parser. Each finished header becomes one job in the queue.
    logic job_push, q_full, q_empty, q_pop;
    job_t job_in, job_out;

    cth_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .header_byte   (header_byte),
        .header_absent (header_absent),
        .last_byte     (last_byte),
        .body_length   (body_length),
        .json_mode     (json_mode_reg),
        .job_valid     (job_push),
        .job           (job_in),
        .job_full      (q_full)
    );

    cth_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (q_full),
        .empty     (q_empty),
        .pop       (q_pop),
        .pop_data  (job_out)
    );

    // Back: body length compare and verdict register.
    cth_verdict u_verdict (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_ready  (!q_empty),
        .job        (job_out),
        .job_pop    (q_pop),
        .body_limit (body_limit_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .verdict    (verdict)
    );

endmodule

// ===== test/content_type_header_checker_test.sv =====
`timescale 1ns / 100ps

module content_type_header_checker_test;
    import cth_pkg::*;

    // Scoreboard: holds its own copy of the header parser and the configuration,
    // predicts a verdict for each request that carries the last byte, and checks
    // the verdicts that leave the block in order.
    class verdict_board;
        bit          json_mode;
        logic [31:0] body_limit;
        phase_t      phase;
        int          type_len;
        bit          space_seen;
        logic [3:0]  type_flags;
        logic [39:0] tail;
        int          name_pos;
        int          value_pos;
        bit          charset_seen;
        err_t        first_err;
        verdict_t    pending_verdicts[$];
        int          errors;

        function void clear_header();
            phase = PH_TYPE_LEAD;
            type_len = 0;
            space_seen = 0;
            type_flags = 4'hF;
            tail = '0;
            name_pos = 0;
            value_pos = 0;
            charset_seen = 0;
            first_err = ERR_NONE;
        endfunction

        function void reset_all();
            json_mode = 0;
            body_limit = 32'd102400;
            pending_verdicts.delete();
            errors = 0;
            clear_header();
        endfunction

        function bit tok(logic [7:0] c);
            string specials;
            specials = "!#$%&'*+-.^_`|~";
            if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
                return 1;
            for (int i = 0; i < specials.len(); i++)
                if (specials[i] == c) return 1;
            return 0;
        endfunction

        function logic [7:0] low(logic [7:0] c);
            return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        endfunction

        function bit ws(logic [7:0] c);
            return c == " " || c == 8'h09;
        endfunction

        function bit ctl(logic [7:0] c);
            return (c < 8'd32 && c != 8'h09) || c == 8'd127;
        endfunction

        function void fail(err_t e);
            if (first_err == ERR_NONE) first_err = e;
            phase = PH_ERR;
        endfunction

        function void add_type(logic [7:0] raw);
            string jt, ft, ap;
            logic [7:0] c;
            jt = "application/json";
            ft = "application/x-www-form-urlencoded";
            ap = "application/";
            c = low(raw);
            if (space_seen) type_flags = 0;
            if (!(type_len < 16 && c == jt[type_len])) type_flags[0] = 0;
            if (type_len < 12) begin
                if (c != ap[type_len]) type_flags[1] = 0;
            end
            else if (!tok(c)) begin
                type_flags[1] = 0;
            end
            if (!(type_len < 33 && c == ft[type_len])) type_flags[2] = 0;
            if (type_len < 34) type_len++;
            tail = {tail[31:0], c};
        endfunction

        function void add_name(logic [7:0] raw);
            string cs;
            cs = "charset";
            if (name_pos < 7 && low(raw) == cs[name_pos]) name_pos++;
            else name_pos = 15;
        endfunction

        function void add_value(logic [7:0] raw);
            string u;
            u = "utf-8";
            if (value_pos < 5 && low(raw) == u[value_pos]) value_pos++;
            else value_pos = 15;
        endfunction

        function void close_param();
            if (name_pos == 7) begin
                if (charset_seen) fail(ERR_MALFORMED);
                else begin
                    charset_seen = 1;
                    if (value_pos != 5) fail(ERR_UNSUPPORTED);
                end
            end
            name_pos = 0;
            value_pos = 0;
        endfunction

        function void next_param();
            close_param();
            if (phase != PH_ERR) phase = PH_NAME_LEAD;
        endfunction

        function void parse(logic [7:0] c);
            case (phase)
                PH_TYPE_LEAD:
                    if (c == ";") phase = PH_NAME_LEAD;
                    else if (!ws(c)) begin phase = PH_TYPE; add_type(c); end
                PH_TYPE:
                    if (c == ";") phase = PH_NAME_LEAD;
                    else if (ws(c)) space_seen = 1;
                    else add_type(c);
                PH_NAME_LEAD:
                    if (tok(c)) begin phase = PH_NAME; add_name(c); end
                    else if (!ws(c)) fail(ERR_MALFORMED);
                PH_NAME:
                    if (tok(c)) add_name(c);
                    else if (ws(c)) phase = PH_AFTER_NAME;
                    else if (c == "=") phase = PH_VALUE_LEAD;
                    else fail(ERR_MALFORMED);
                PH_AFTER_NAME:
                    if (c == "=") phase = PH_VALUE_LEAD;
                    else if (!ws(c)) fail(ERR_MALFORMED);
                PH_VALUE_LEAD:
                    if (c == "\"") phase = PH_QUOTED;
                    else if (tok(c)) begin phase = PH_TOKEN_VALUE; add_value(c); end
                    else if (!ws(c)) fail(ERR_MALFORMED);
                PH_TOKEN_VALUE:
                    if (tok(c)) add_value(c);
                    else if (ws(c)) phase = PH_AFTER_VALUE;
                    else if (c == ";") next_param();
                    else fail(ERR_MALFORMED);
                PH_QUOTED:
                    if (c == "\"") phase = PH_AFTER_VALUE;
                    else if (c == "\\") phase = PH_QUOTED_ESC;
                    else if (ctl(c)) fail(ERR_MALFORMED);
                    else add_value(c);
                PH_QUOTED_ESC:
                    if (ctl(c)) fail(ERR_MALFORMED);
                    else begin add_value(c); phase = PH_QUOTED; end
                PH_AFTER_VALUE:
                    if (c == ";") next_param();
                    else if (!ws(c)) fail(ERR_MALFORMED);
                default: ;
            endcase
        endfunction

        // Notes one accepted request and queues a verdict when the header ends.
        function void note_request(logic [7:0] c, bit absent, bit last, logic [31:0] blen);
            bit matched;
            verdict_t v;
            if (absent) begin
                if (last) begin
                    clear_header();
                    pending_verdicts.push_back(V_NO_MATCH);
                end
                return;
            end
            parse(c);
            if (!last) return;
            case (phase)
                PH_TOKEN_VALUE, PH_AFTER_VALUE: close_param();
                PH_NAME_LEAD, PH_NAME, PH_AFTER_NAME, PH_VALUE_LEAD,
                PH_QUOTED, PH_QUOTED_ESC: fail(ERR_MALFORMED);
                default: ;
            endcase
            if (json_mode)
                matched = (type_flags[0] && type_len == 16) ||
                          (type_flags[1] && type_len > 17 && tail == 40'h2B6A736F6E);
            else
                matched = type_flags[2] && type_len == 33;
            if (!matched) v = V_NO_MATCH;
            else if (blen > body_limit) v = V_TOO_LARGE;
            else if (first_err == ERR_MALFORMED) v = V_MALFORMED;
            else if (first_err == ERR_UNSUPPORTED) v = V_UNSUPPORTED;
            else v = V_MATCH;
            clear_header();
            pending_verdicts.push_back(v);
        endfunction

        // Prints one mismatch line and counts it.
        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_verdict(logic [2:0] got);
            verdict_t want;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("verdict %0d with none expected", got));
                return;
            end
            want = pending_verdicts.pop_front();
            if (got !== want)
                report($sformatf("verdict %0d, expected %0d", got, want));
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [7:0]  header_byte = 0;
    logic        header_absent = 0;
    logic        last_byte = 0;
    logic [31:0] body_length = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [2:0]  verdict;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [31:0] cfg_data = 0;

    verdict_board board = new();
    bit  idle_on = 1;
    int  stall_cycles;
    int  header_count;

    always #5 clk = ~clk;

    content_type_header_checker u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .header_byte(header_byte), .header_absent(header_absent),
        .last_byte(last_byte), .body_length(body_length),
        .out_valid(out_valid), .out_ready(out_ready), .verdict(verdict),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Results are checked at the rising edge; requests are noted there too, so
    // the prediction sees exactly what the block accepted.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) board.check_verdict(verdict);
            if (in_valid && in_ready)
                board.note_request(header_byte, header_absent, last_byte, body_length);
            if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles > 5000) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // The receiver stalls in random bursts while idling is enabled.
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 9) == 0) begin
                out_ready <= 0;
                n = $urandom_range(1, 19);
                repeat (n) @(negedge clk);
            end
            out_ready <= 1;
        end
    end

    task automatic write_reg(logic idx, logic [31:0] data);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 0;
        if (idx == CFG_JSON_MODE) board.json_mode = data[0];
        else board.body_limit = data;
    endtask

    // Stops sending, waits until every verdict has arrived, then lets the
    // pipeline drain.
    task automatic drain();
        in_valid <= 0;
        while (board.pending_verdicts.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Sends one request; the caller is at a falling edge. Valid stays high
    // afterwards so that requests can follow back to back.
    task automatic send(logic [7:0] c, bit absent, bit last, logic [31:0] blen);
        int n;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            in_valid <= 0;
            n = $urandom_range(1, 19);
            repeat (n) @(negedge clk);
        end
        in_valid <= 1;
        header_byte <= c;
        header_absent <= absent;
        last_byte <= last;
        body_length <= blen;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_header(string s, logic [31:0] blen);
        for (int i = 0; i < s.len(); i++)
            send(s[i], 0, i == s.len() - 1, blen);
        header_count++;
    endtask

    function automatic logic [31:0] rand_len();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 0;
            2: return board.body_limit;
            3: return board.body_limit + 1;
            default: return $urandom_range(0, 200000);
        endcase
    endfunction

    function automatic string pick_char(string pool);
        string r;
        r = " ";
        r[0] = pool[$urandom_range(0, pool.len() - 1)];
        return r;
    endfunction

    // Builds a header that is mostly well formed, with random damage.
    function automatic string rand_header();
        string types[6];
        string values[7];
        string s, mix;
        int np;
        mix = "aZ09!#$%&'*+-.^_`|~ \t;=\"\\\x01\x7f\xe9,/()";
        types[0] = "application/json";
        types[1] = "Application/X-WWW-Form-URLEncoded";
        types[2] = "application/vnd.api+json";
        types[3] = "application/ld+JSON";
        types[4] = "text/plain";
        types[5] = "application/x-www-form-urlencode";
        values[0] = "utf-8";
        values[1] = "UTF-8";
        values[2] = "\"utf-8\"";
        values[3] = "\"u\\tf-8\"";
        values[4] = "latin1";
        values[5] = "\"a b\xff\"";
        values[6] = "utf-8x";
        s = ($urandom_range(0, 3) == 0) ? " \t" : "";
        s = {s, types[$urandom_range(0, 5)]};
        if ($urandom_range(0, 9) == 0) s = {s, " x"};
        if ($urandom_range(0, 3) == 0) s = {s, "\t "};
        np = $urandom_range(0, 3);
        for (int i = 0; i < np; i++) begin
            s = {s, ";", ($urandom_range(0, 2) == 0) ? " " : ""};
            s = {s, ($urandom_range(0, 1) == 0) ? "charset" : "Boundary"};
            s = {s, ($urandom_range(0, 4) == 0) ? " = " : "="};
            s = {s, values[$urandom_range(0, 6)]};
            if ($urandom_range(0, 4) == 0) s = {s, " "};
        end
        // Noise: a random byte appended, or a fully random string.
        if ($urandom_range(0, 4) == 0) s = {s, pick_char(mix)};
        if ($urandom_range(0, 9) == 0) begin
            s = "";
            np = $urandom_range(1, 12);
            for (int i = 0; i < np; i++) begin
                mix[0] = 8'($urandom_range(0, 255));
                s = {s, pick_char(mix)};
            end
        end
        return s;
    endfunction

    initial begin
        string s;
        header_count = 0;
        stall_cycles = 0;
        board.reset_all();
        repeat (11) @(negedge clk);
        rst_n = 1;
        out_ready = 1;

        // Directed headers in form mode first, then JSON mode.
        write_reg(CFG_BODY_LIMIT, 32'd100);
        send_header("application/x-www-form-urlencoded", 100);
        send_header(" APPLICATION/x-www-form-urlencoded ;charset=utf-8", 101);
        send(8'hFF, 1, 0, 0);                 // absent without last: ignored
        send(8'h41, 1, 1, 0);                 // absent with last
        send_header("application/x-www-form-urlencoded;", 0);
        send_header("application/x-www-form-urlencoded;;a=b", 0);
        send_header("application/x-www-form-urlencoded; a", 0);
        send_header("application/x-www-form-urlencoded;a=", 0);
        send_header("application/x-www-form-urlencoded;a=\"x\x01\"", 0);
        send_header("application/x-www-form-urlencoded;a=\"x\\\x7f\"", 0);
        send_header("application/x-www-form-urlencoded;a=\"x\\", 0);
        send_header("application/x-www-form-urlencoded;a=\"x\xff", 0);
        send_header("application/x-www-form-urlencoded;charset=latin1;x=(", 0);
        send_header("application/x-www-form-urlencoded;charset=utf-8;CHARSET=utf-8", 0);
        send_header("application/x-www form-urlencoded", 0);
        drain();
        write_reg(CFG_JSON_MODE, 1);
        write_reg(CFG_BODY_LIMIT, 32'hFFFF_FFFF);
        send_header("application/json", 32'hFFFF_FFFF);
        send_header("application/a+json", 0);
        send_header("application/+json", 0);
        send_header("application/json; charset=\"UTF-\\8\"", 0);
        send_header(";a=b", 0);
        drain();
        write_reg(CFG_BODY_LIMIT, 0);
        send_header("application/json", 1);
        send_header("application/json", 0);

        // Random headers over several configurations.
        for (int phase_n = 0; phase_n < 3; phase_n++) begin
            drain();
            write_reg(CFG_JSON_MODE, $urandom_range(0, 1));
            case (phase_n)
                0: write_reg(CFG_BODY_LIMIT, 0);
                1: write_reg(CFG_BODY_LIMIT, 32'hFFFF_FFFF);
                default: write_reg(CFG_BODY_LIMIT, $urandom_range(0, 200000));
            endcase
            if (phase_n == 2) idle_on = 0;
            for (int k = 0; k < 1; k++) begin
                s = rand_header();
                if (s.len() == 0 || $urandom_range(0, 19) == 0) send(8'h00, 1, 1, 0);
                else send_header(s, rand_len());
                if ($urandom_range(0, 30) == 0) send(8'($urandom_range(0, 255)), 1, 0, 0);
            end
            if (phase_n == 1) drain();        // sender holds off until all verdicts are in
            for (int k = 0; k < 1; k++) begin
                s = rand_header();
                if (s.len() == 0) s = "x";
                send_header(s, rand_len());
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (board.errors == 0 && board.pending_verdicts.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
